// ===== src/llct2_pkg.sv =====
package llct2_pkg;

  localparam int NTYPES = 19;

  typedef enum logic [1:0] {
    CMD_UNNUM  = 2'd0,
    CMD_INFO   = 2'd1,
    CMD_RESEND = 2'd2,
    CMD_ACK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_LOCAL_SAP  = 1'b0,
    CFG_REMOTE_SAP = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RESEND,
    BK_ACK
  } bk_state_t;

  // control byte per pdu type
  function automatic logic [7:0] ctl_byte(input logic [4:0] t);
    case (t)
      5'd0, 5'd6:   ctl_byte = 8'h00;
      5'd1, 5'd7:   ctl_byte = 8'h01;
      5'd2, 5'd8:   ctl_byte = 8'h05;
      5'd3, 5'd9:   ctl_byte = 8'h09;
      5'd4:         ctl_byte = 8'h43;
      5'd5:         ctl_byte = 8'h7F;
      5'd10:        ctl_byte = 8'h63;
      5'd11:        ctl_byte = 8'h0F;
      5'd12:        ctl_byte = 8'h87;
      5'd13:        ctl_byte = 8'hFF;
      5'd14:        ctl_byte = 8'h03;
      5'd15, 5'd17: ctl_byte = 8'hBF;
      5'd16, 5'd18: ctl_byte = 8'hE3;
      default:      ctl_byte = 8'h00;
    endcase
  endfunction

  // header length per pdu type
  function automatic logic [2:0] hdr_len(input logic [4:0] t);
    case (t)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd6, 5'd7, 5'd8, 5'd9: hdr_len = 3'd4;
      5'd13:   hdr_len = 3'd0;
      default: hdr_len = 3'd3;
    endcase
  endfunction

  // command/response bit per pdu type
  function automatic logic cr_bit(input logic [4:0] t);
    case (t)
      5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd17, 5'd18: cr_bit = 1'b1;
      default: cr_bit = 1'b0;
    endcase
  endfunction

endpackage

// ===== src/llc_type2_send_and_retransmit_queue.sv =====
// a single-result command presents its result the cycle after the back takes it, so an
// input transfer reaches the output through the front queue and the back result register
// resend and ack: a registered memory read, then one result per cycle unless stalled
// throughput: one send command per cycle unless stalled; a walk holds off new commands
// reset: rst synchronous, clears configuration, send sequence, queue pointers and fill
module llc_type2_send_and_retransmit_queue #(
  parameter int QUEUE_DEPTH = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [7:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // command[1:0], frame_type[6:2], poll_final[8:7], receive_seq[15:9],
  // ack_seq[22:16], buffer_handle, data_length, zero fill
  input  logic [((34 + HANDLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // status, dsap_byte, ssap_byte, control_first, control_second,
  // frame_length, result_handle, entry_count, zero fill
  output logic [((52 + HANDLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic m_axis_tlast
);
  import llct2_pkg::*;

  localparam int OW = ((52 + HANDLE_BITS + 7) / 8) * 8;

  logic [7:0] own_sap, peer_sap;
  logic q_valid, q_ready;
  logic [1:0] q_cmd, q_pf, o_status;
  logic [4:0] q_ftype;
  logic [6:0] q_nr, q_ack, o_count;
  logic [HANDLE_BITS-1:0] q_handle, o_handle;
  logic [10:0] q_dlen, o_flen;
  logic [7:0] o_dsap, o_ssap, o_c1, o_c2;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_sap <= '0;
      peer_sap <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_LOCAL_SAP) own_sap <= cfg_data;
      else peer_sap <= cfg_data;
    end
  end

  llct2_front #(.HANDLE_BITS(HANDLE_BITS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_cmd(s_axis_tdata[1:0]), .in_ftype(s_axis_tdata[6:2]),
    .in_pf(s_axis_tdata[8:7]), .in_nr(s_axis_tdata[15:9]),
    .in_ack(s_axis_tdata[22:16]),
    .in_handle(s_axis_tdata[23 +: HANDLE_BITS]),
    .in_dlen(s_axis_tdata[23 + HANDLE_BITS +: 11]),
    .q_valid, .q_ready, .q_cmd, .q_ftype, .q_pf, .q_nr, .q_ack,
    .q_handle, .q_dlen
  );

  llct2_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .HANDLE_BITS(HANDLE_BITS)) u_back (
    .clk, .rst, .own_sap, .peer_sap,
    .q_valid, .q_ready, .q_cmd, .q_ftype, .q_pf, .q_nr, .q_ack,
    .q_handle, .q_dlen,
    .o_valid(m_axis_tvalid), .o_ready(m_axis_tready),
    .o_status, .o_dsap, .o_ssap, .o_c1, .o_c2, .o_flen, .o_handle,
    .o_count, .o_last(m_axis_tlast)
  );

  assign m_axis_tdata = OW'({o_count, o_handle, o_flen, o_c2, o_c1,
                             o_ssap, o_dsap, o_status});

endmodule

// ===== src/llct2_front.sv =====
module llct2_front #(
  parameter int HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_cmd,
  input  logic [4:0]             in_ftype,
  input  logic [1:0]             in_pf,
  input  logic [6:0]             in_nr,
  input  logic [6:0]             in_ack,
  input  logic [HANDLE_BITS-1:0] in_handle,
  input  logic [10:0]            in_dlen,
  output logic                   q_valid,
  input  logic                   q_ready,
  output logic [1:0]             q_cmd,
  output logic [4:0]             q_ftype,
  output logic [1:0]             q_pf,
  output logic [6:0]             q_nr,
  output logic [6:0]             q_ack,
  output logic [HANDLE_BITS-1:0] q_handle,
  output logic [10:0]            q_dlen
);
  import llct2_pkg::*;

  // single-entry command queue between front and back
  assign in_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_cmd    <= in_cmd;
      q_ftype  <= in_ftype;
      q_pf     <= in_pf;
      q_nr     <= in_nr;
      q_ack    <= in_ack;
      q_handle <= in_handle;
      q_dlen   <= in_dlen;
    end
  end

  holds_stalled: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_ready |=> q_valid && $stable(q_cmd))
    else $error("queued command lost while stalled");
  ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> in_ready)
    else $error("front blocked while empty");
  accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> q_valid)
    else $error("accepted command not queued");

endmodule

// ===== src/llct2_back.sv =====
module llct2_back #(
  parameter int QUEUE_DEPTH = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             own_sap,
  input  logic [7:0]             peer_sap,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  logic [1:0]             q_cmd,
  input  logic [4:0]             q_ftype,
  input  logic [1:0]             q_pf,
  input  logic [6:0]             q_nr,
  input  logic [6:0]             q_ack,
  input  logic [HANDLE_BITS-1:0] q_handle,
  input  logic [10:0]            q_dlen,
  output logic                   o_valid,
  input  logic                   o_ready,
  output logic [1:0]             o_status,
  output logic [7:0]             o_dsap,
  output logic [7:0]             o_ssap,
  output logic [7:0]             o_c1,
  output logic [7:0]             o_c2,
  output logic [10:0]            o_flen,
  output logic [HANDLE_BITS-1:0] o_handle,
  output logic [6:0]             o_count,
  output logic                   o_last
);
  import llct2_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  logic [HANDLE_BITS-1:0] mem_h [QUEUE_DEPTH];
  logic [6:0]             mem_s [QUEUE_DEPTH];

  bk_state_t state, state_next;
  logic [6:0]    send_seq;
  logic [AW-1:0] head, tail, rd_ptr, walk_addr;
  logic [FW-1:0] fill;
  logic [6:0]    cnt;
  logic          ftype_nz;
  logic          cur_p;
  logic [6:0]    cur_nr, target;
  logic          rd_pend;
  logic [HANDLE_BITS-1:0] rd_h;
  logic [6:0]    rd_s;

  logic out_free, walk_step, take, hit, last_walk, walk_cmd;
  logic [11:0] flen_sum;
  logic [7:0]  ctl_raw;
  logic [7:0]  c1u;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
    nxt = (32'(i) + 1 >= QUEUE_DEPTH) ? '0 : AW'(32'(i) + 1);
  endfunction

  assign out_free = !o_valid || o_ready;
  assign take     = (state == BK_IDLE) && q_valid && out_free && !rd_pend;
  assign q_ready  = take;
  assign walk_cmd = (q_cmd == CMD_RESEND || q_cmd == CMD_ACK) && fill != '0;
  // walk emits when registered read data is ready
  assign walk_step = (state != BK_IDLE) && rd_pend && out_free;
  assign hit       = (rd_s == target);
  // acknowledge shrinks fill as it walks, resend keeps it
  assign last_walk = (state == BK_ACK) ? (hit || fill == FW'(1)) :
                     (FW'(cnt) + FW'(1) == fill);
  assign flen_sum  = {1'b0, q_dlen} + 12'(hdr_len(q_ftype));
  assign ctl_raw   = ctl_byte(q_ftype);
  assign c1u       = ctl_raw | {3'b0, q_pf[0], 4'b0};

  // read address: head on start, next entry on each emitted step
  always_comb begin
    if (take) rd_ptr = head;
    else if (walk_step) rd_ptr = nxt(walk_addr);
    else rd_ptr = walk_addr;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (take && fill != '0) begin
          if (q_cmd == CMD_RESEND) state_next = BK_RESEND;
          else if (q_cmd == CMD_ACK) state_next = BK_ACK;
        end
      end
      BK_RESEND, BK_ACK: if (walk_step && last_walk) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // memory read port
  always_ff @(posedge clk) begin
    rd_h <= mem_h[rd_ptr];
    rd_s <= mem_s[rd_ptr];
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (take && q_cmd == CMD_INFO && (q_ftype == 5'd0 || q_ftype == 5'd6) &&
        fill < FW'(QUEUE_DEPTH)) begin
      mem_h[tail] <= q_handle;
      mem_s[tail] <= send_seq;
    end else if (walk_step && state == BK_RESEND) begin
      mem_s[walk_addr] <= send_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      send_seq <= '0;
      head <= '0;
      tail <= '0;
      fill <= '0;
      rd_pend <= 1'b0;
      o_valid <= 1'b0;
      walk_addr <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      o_valid <= walk_step || (take && !walk_cmd) || (o_valid && !o_ready);
      if (take) begin
        walk_addr <= head;
        cnt <= '0;
        if (q_cmd == CMD_INFO && (q_ftype == 5'd0 || q_ftype == 5'd6) &&
            fill < FW'(QUEUE_DEPTH)) begin
          tail <= nxt(tail);
          fill <= fill + FW'(1);
          send_seq <= send_seq + 7'd1;
        end
        if (walk_cmd) begin
          rd_pend <= 1'b1;
          if (q_cmd == CMD_RESEND) send_seq <= q_ack;
        end
      end
      if (walk_step) begin
        cnt <= cnt + 7'd1;
        walk_addr <= nxt(walk_addr);
        rd_pend <= !last_walk;
        if (state == BK_RESEND) begin
          send_seq <= send_seq + 7'd1;
        end else begin
          head <= nxt(head);
          fill <= fill - FW'(1);
        end
      end
    end
  end

  // command context for the walk
  always_ff @(posedge clk) begin
    if (take) begin
      cur_p <= q_pf[0];
      cur_nr <= q_nr;
      target <= q_ack - 7'd1;
      ftype_nz <= (q_ftype != 5'd0);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (take) begin
      o_status <= ST_OK;
      o_dsap <= '0; o_ssap <= '0; o_c1 <= '0; o_c2 <= '0;
      o_flen <= '0; o_handle <= '0; o_count <= '0; o_last <= 1'b1;
      case (q_cmd)
        CMD_UNNUM: begin
          if (q_ftype >= 5'(NTYPES)) o_status <= ST_BAD;
          else begin
            o_dsap <= q_pf[1] ? 8'h00 : peer_sap;
            o_ssap <= own_sap + {7'b0, cr_bit(q_ftype)};
            if (ctl_raw[1:0] == 2'b01) begin
              o_c1 <= ctl_raw;
              o_c2 <= {q_nr, q_pf[0]};
            end else begin
              o_c1 <= c1u;
            end
            o_flen <= flen_sum[11] ? 11'h7FF : flen_sum[10:0];
          end
        end
        CMD_INFO: begin
          if (!(q_ftype == 5'd0 || q_ftype == 5'd6)) o_status <= ST_BAD;
          else if (fill >= FW'(QUEUE_DEPTH)) o_status <= ST_FULL;
          else begin
            o_dsap <= peer_sap;
            o_ssap <= own_sap + {7'b0, cr_bit(q_ftype)};
            o_c1 <= {send_seq, 1'b0};
            o_c2 <= {q_nr, q_pf[0]};
            o_handle <= q_handle;
          end
        end
        default: if (fill == '0) o_status <= ST_EMPTY;
      endcase
    end else if (walk_step) begin
      o_status <= ST_OK;
      o_handle <= rd_h;
      o_count <= cnt + 7'd1;
      o_last <= last_walk;
      o_flen <= '0;
      if (state == BK_RESEND) begin
        o_dsap <= peer_sap;
        o_ssap <= {own_sap[7:1], (cnt == '0) ? ftype_nz : 1'b0};
        o_c1 <= {send_seq, 1'b0};
        o_c2 <= {cur_nr, (cnt == '0) ? cur_p : 1'b0};
      end else begin
        o_dsap <= '0; o_ssap <= '0; o_c1 <= '0; o_c2 <= '0;
      end
    end
  end

  fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");
  walk_has_entries: assert property (@(posedge clk) disable iff (rst)
    state != BK_IDLE |-> fill != '0)
    else $error("walking an empty queue");
  no_take_walking: assert property (@(posedge clk) disable iff (rst)
    state != BK_IDLE |-> !q_ready)
    else $error("command taken during walk");
  out_hold: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_ready |=> o_valid && $stable(o_handle))
    else $error("result dropped while stalled");

endmodule

// ===== bench/llct2_frame_checker.sv =====
`timescale 1ns / 100ps

module llct2_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending
);
  import llct2_pkg::*;

  // most significant member first, matching {tlast, tdata}
  typedef struct packed {
    logic        last;
    logic [6:0]  count;
    logic [15:0] handle;
    logic [10:0] flen;
    logic [7:0]  ctl2;
    logic [7:0]  ctl1;
    logic [7:0]  ssap;
    logic [7:0]  dsap;
    logic [1:0]  status;
  } hdr_result_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [6:0]  seq;
  } queued_frame_t;

  localparam logic [7:0] CTL_TAB [19] = '{8'h00, 8'h01, 8'h05, 8'h09, 8'h43, 8'h7F, 8'h00,
    8'h01, 8'h05, 8'h09, 8'h63, 8'h0F, 8'h87, 8'hFF, 8'h03, 8'hBF, 8'hE3, 8'hBF, 8'hE3};
  localparam logic [2:0] LEN_TAB [19] = '{3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd0, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3};
  localparam logic CR_TAB [19] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};

  logic [7:0]    own_sap;
  logic [7:0]    peer_sap;
  logic [6:0]    next_ns;
  queued_frame_t retx_q[$];
  hdr_result_t   expected_hdrs[$];

  function automatic hdr_result_t status_only(input status_t st);
    hdr_result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // work out the headers caused by one command transfer
  task automatic predict_command(input logic [55:0] d);
    cmd_t        cmd;
    logic [4:0]  ft;
    logic [1:0]  pf;
    logic [6:0]  nr;
    logic [6:0]  ackv;
    logic [15:0] h;
    logic [10:0] dlen;
    logic [11:0] sum;
    logic [6:0]  target;
    hdr_result_t r;
    bit          hit;
    int          k;
    cmd  = cmd_t'(d[1:0]);
    ft   = d[6:2];
    pf   = d[8:7];
    nr   = d[15:9];
    ackv = d[22:16];
    h    = d[38:23];
    dlen = d[49:39];
    r = '0;
    r.last = 1'b1;
    case (cmd)
      CMD_UNNUM: begin
        if (ft > 5'd18) begin
          expected_hdrs.push_back(status_only(ST_BAD));
        end else begin
          r.status = ST_OK;
          r.dsap = pf[1] ? 8'h00 : peer_sap;
          r.ssap = own_sap + {7'b0, CR_TAB[ft]};
          r.ctl1 = CTL_TAB[ft];
          // supervisory frames carry N(R), the rest put P/F in bit 4
          if (CTL_TAB[ft][1:0] == 2'b01) r.ctl2 = {nr, pf[0]};
          else r.ctl1[4] = r.ctl1[4] | pf[0];
          sum = {1'b0, dlen} + 12'(LEN_TAB[ft]);
          r.flen = sum[11] ? 11'h7FF : sum[10:0];
          expected_hdrs.push_back(r);
        end
      end
      CMD_INFO: begin
        if (ft != 5'd0 && ft != 5'd6) begin
          expected_hdrs.push_back(status_only(ST_BAD));
        end else if (retx_q.size() >= 64) begin
          expected_hdrs.push_back(status_only(ST_FULL));
        end else begin
          retx_q.push_back('{handle: h, seq: next_ns});
          r.status = ST_OK;
          r.dsap = peer_sap;
          r.ssap = own_sap + {7'b0, CR_TAB[ft]};
          r.ctl1 = {next_ns, 1'b0};
          r.ctl2 = {nr, pf[0]};
          r.handle = h;
          expected_hdrs.push_back(r);
          next_ns = next_ns + 7'd1;
        end
      end
      default: begin
        if (retx_q.size() == 0) begin
          expected_hdrs.push_back(status_only(ST_EMPTY));
        end else if (cmd == CMD_RESEND) begin
          // renumber everything queued starting from ack_seq
          next_ns = ackv;
          for (k = 0; k < retx_q.size(); k++) begin
            retx_q[k].seq = next_ns;
            r = '0;
            r.status = ST_OK;
            r.dsap = peer_sap;
            r.ssap = {own_sap[7:1], (k == 0 && ft != 5'd0)};
            r.ctl1 = {next_ns, 1'b0};
            r.ctl2 = {nr, (k == 0) ? pf[0] : 1'b0};
            r.handle = retx_q[k].handle;
            r.count = 7'(k + 1);
            r.last = (k == retx_q.size() - 1);
            expected_hdrs.push_back(r);
            next_ns = next_ns + 7'd1;
          end
        end else begin
          // release from the front up to N(S) = ack_seq - 1
          target = ackv - 7'd1;
          k = 0;
          hit = 0;
          while (retx_q.size() > 0 && !hit) begin
            hit = (retx_q[0].seq == target);
            r = '0;
            r.status = ST_OK;
            r.handle = retx_q[0].handle;
            r.count = 7'(k + 1);
            void'(retx_q.pop_front());
            r.last = hit || (retx_q.size() == 0);
            expected_hdrs.push_back(r);
            k++;
          end
        end
      end
    endcase
  endtask

  // register writes, command transfers and result checks
  always @(posedge clk) begin
    hdr_result_t exp_r;
    hdr_result_t act_r;
    if (rst) begin
      own_sap <= 8'h00;
      peer_sap <= 8'h00;
      next_ns = 7'd0;
      retx_q.delete();
      expected_hdrs.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_reg_t'(cfg_index) == CFG_LOCAL_SAP) own_sap <= cfg_data;
        else peer_sap <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) predict_command(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        act_r = {m_axis_tlast, m_axis_tdata[67:0]};
        if (expected_hdrs.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", act_r);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_hdrs.pop_front();
          if (act_r !== exp_r) begin
            if (fail_count < 10)
              $display("mismatch at %0t: expected %p actual %p", $realtime, exp_r, act_r);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_hdrs.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import llct2_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // command, frame_type, poll_final, receive_seq, ack_seq, buffer_handle,
  // data_length, zero fill
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // status, dsap_byte, ssap_byte, control_first, control_second,
  // frame_length, result_handle, entry_count, zero fill
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;

  int          fail_count;
  int          pending;
  bit          calm;
  bit          hold_go;
  bit          hold_used;
  int          hold_cnt;
  int          quiet_cycles;
  logic [6:0]  seq_shadow[$];
  logic [6:0]  ns_shadow;

  llc_type2_send_and_retransmit_queue DUT (.*);

  llct2_frame_checker u_checker (.*);

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_cnt <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 20);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == 5000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // wait until the block is drained, then write one register
  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
    bit ok;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
      if (ok) break;
    end
    cfg_valid <= 1'b0;
  endtask

  // one command transfer, also tracking queued N(S) to aim acknowledges
  task automatic send_cmd(input cmd_t cmd, input logic [4:0] ft, input logic [1:0] pf,
                          input logic [6:0] nr, input logic [6:0] ackv,
                          input logic [15:0] h, input logic [10:0] dlen);
    bit ok;
    bit hit;
    int k;
    if (!calm && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, dlen, h, ackv, nr, pf, ft, cmd};
    forever begin
      @(negedge clk);
      ok = s_axis_tready;
      @(posedge clk);
      if (ok) break;
    end
    if (cmd == CMD_INFO && (ft == 5'd0 || ft == 5'd6) && seq_shadow.size() < 64) begin
      seq_shadow.push_back(ns_shadow);
      ns_shadow = ns_shadow + 7'd1;
    end else if (cmd == CMD_RESEND && seq_shadow.size() > 0) begin
      ns_shadow = ackv;
      for (k = 0; k < seq_shadow.size(); k++) begin
        seq_shadow[k] = ns_shadow;
        ns_shadow = ns_shadow + 7'd1;
      end
    end else if (cmd == CMD_ACK) begin
      hit = 0;
      while (seq_shadow.size() > 0 && !hit) hit = (seq_shadow.pop_front() == ackv - 7'd1);
    end
  endtask

  // one random command, mostly well formed
  task automatic random_cmd();
    int r;
    logic [6:0] ackv;
    r = $urandom_range(99);
    ackv = 7'($urandom);
    if (seq_shadow.size() > 0 && $urandom_range(99) < 80)
      ackv = seq_shadow[$urandom_range(seq_shadow.size() - 1)] + 7'd1;
    if (r < 40)
      send_cmd(CMD_INFO, $urandom_range(1) ? 5'd0 : 5'd6, 2'($urandom), 7'($urandom),
               7'($urandom), 16'($urandom), 11'($urandom));
    else if (r < 60)
      send_cmd(CMD_UNNUM, 5'($urandom_range(18)), 2'($urandom), 7'($urandom),
               7'($urandom), 16'($urandom), 11'($urandom));
    else if (r < 72)
      send_cmd(CMD_RESEND, $urandom_range(1) ? 5'd0 : 5'($urandom), 2'($urandom),
               7'($urandom), ackv, 16'($urandom), 11'($urandom));
    else if (r < 94)
      send_cmd(CMD_ACK, 5'($urandom), 2'($urandom), 7'($urandom), ackv, 16'($urandom),
               11'($urandom));
    else
      send_cmd(cmd_t'($urandom_range(1)), 5'($urandom_range(19, 31)), 2'($urandom),
               7'($urandom), 7'($urandom), 16'($urandom), 11'($urandom));
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_LOCAL_SAP;
    cfg_data <= 8'h00;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    calm = 1'b0;
    hold_go <= 1'b0;
    ns_shadow = 7'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(CFG_LOCAL_SAP, 8'h42);
    write_reg(CFG_REMOTE_SAP, 8'hF0);

    // directed: empty queue, table corners, bad types, saturation, numbering
    send_cmd(CMD_RESEND, 5'd0, 2'd0, 7'd0, 7'd0, 16'h0, 11'd0);
    send_cmd(CMD_ACK, 5'd0, 2'd0, 7'd0, 7'd0, 16'h0, 11'd0);
    send_cmd(CMD_UNNUM, 5'd0, 2'd3, 7'd127, 7'd0, 16'h0, 11'd0);
    send_cmd(CMD_UNNUM, 5'd1, 2'd1, 7'd127, 7'd0, 16'h0, 11'd2047);
    send_cmd(CMD_UNNUM, 5'd4, 2'd1, 7'd0, 7'd0, 16'h0, 11'd1500);
    send_cmd(CMD_UNNUM, 5'd5, 2'd2, 7'd0, 7'd0, 16'h0, 11'd0);
    send_cmd(CMD_UNNUM, 5'd13, 2'd3, 7'd5, 7'd0, 16'h0, 11'd2047);
    send_cmd(CMD_UNNUM, 5'd16, 2'd1, 7'd0, 7'd0, 16'h0, 11'd7);
    send_cmd(CMD_UNNUM, 5'd18, 2'd0, 7'd0, 7'd0, 16'h0, 11'd2044);
    send_cmd(CMD_UNNUM, 5'd19, 2'd0, 7'd0, 7'd0, 16'h0, 11'd0);
    send_cmd(CMD_UNNUM, 5'd31, 2'd3, 7'd127, 7'd127, 16'hFFFF, 11'd2047);
    send_cmd(CMD_INFO, 5'd3, 2'd1, 7'd1, 7'd0, 16'h1234, 11'd0);
    send_cmd(CMD_INFO, 5'd0, 2'd1, 7'd127, 7'd0, 16'hFFFF, 11'd0);
    send_cmd(CMD_INFO, 5'd6, 2'd2, 7'd0, 7'd0, 16'h0000, 11'd0);
    send_cmd(CMD_INFO, 5'd6, 2'd0, 7'd64, 7'd0, 16'hA5A5, 11'd0);
    send_cmd(CMD_RESEND, 5'd6, 2'd1, 7'd3, 7'd127, 16'h0, 11'd0);
    send_cmd(CMD_RESEND, 5'd0, 2'd0, 7'd0, 7'd126, 16'h0, 11'd0);
    send_cmd(CMD_ACK, 5'd0, 2'd0, 7'd0, 7'd127, 16'h0, 11'd0);
    send_cmd(CMD_ACK, 5'd0, 2'd0, 7'd0, 7'd50, 16'h0, 11'd0);

    write_reg(CFG_LOCAL_SAP, 8'hFE);
    write_reg(CFG_REMOTE_SAP, 8'h00);

    for (int i = 0; i < 40; i++) begin
      if (i == 8) begin
        // fill the queue past full while the receiver holds off
        hold_go <= 1'b1;
        repeat (68) send_cmd(CMD_INFO, 5'd0, 2'($urandom), 7'($urandom), 7'd0,
                             16'($urandom), 11'($urandom));
        send_cmd(CMD_RESEND, 5'd6, 2'($urandom), 7'($urandom), 7'($urandom),
                 16'($urandom), 11'($urandom));
      end
      if (i == 15) begin
        write_reg(CFG_LOCAL_SAP, 8'h00);
        write_reg(CFG_REMOTE_SAP, 8'hFF);
        calm = 1'b1;
      end
      if (i == 30) calm = 1'b0;
      if (i == 34) begin
        write_reg(CFG_LOCAL_SAP, {7'($urandom_range(127)), 1'b0});
        write_reg(CFG_REMOTE_SAP, 8'($urandom));
      end
      random_cmd();
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
